// File: design/multi_voice_audio_mix_limiter_defines.svh
// Assertion macros used by the audio mix limiter output buffer.
`ifndef MULTI_VOICE_AUDIO_MIX_LIMITER_DEFINES_SVH
`define MULTI_VOICE_AUDIO_MIX_LIMITER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AMX_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AMX_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/amx_pkg.sv
// Shared widths, codes, types and the inverse square root table of the mix limiter.
package amx_pkg;

    localparam int NUM_VOICES = 8;
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 8;
    localparam int COUNT_W    = 4;
    localparam int MODE_W     = 2;
    localparam int GAINS_W    = NUM_VOICES * GAIN_W;
    localparam int IN_FIELDS_W = NUM_VOICES * SAMPLE_W + COUNT_W;
    localparam int IN_DATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam int SUM_W  = 19;
    localparam int ABS_W  = 19;
    localparam int OFF_W  = 18;
    localparam int MAG_W  = 15;
    localparam int DIVD_W = 31;
    localparam int QUO_W  = 14;
    localparam int TAB_W  = 9;

    localparam int KNEE_LEVEL = 24000;
    localparam int KNEE_RANGE = 32767 - 24000;

    localparam logic [COUNT_W-1:0] MAX_PRODUCERS = 4'd8;

    localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HALVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SQRT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MIX_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOICE_GAINS = 2'd1;

    typedef struct packed {
        logic             valid;
        logic             neg;
        logic             knee;
        logic [MAG_W-1:0] mag;
        logic [QUO_W-1:0] quo;
    } t_knee_word;

    // 256/sqrt(n), count already clamped to 8
    function automatic logic [TAB_W-1:0] recip_root(input logic [COUNT_W-1:0] n);
        logic [TAB_W-1:0] v;
        case (n)
            4'd0:    v = 9'd256;
            4'd1:    v = 9'd256;
            4'd2:    v = 9'd181;
            4'd3:    v = 9'd148;
            4'd4:    v = 9'd128;
            4'd5:    v = 9'd114;
            4'd6:    v = 9'd105;
            4'd7:    v = 9'd97;
            default: v = 9'd90;
        endcase
        return v;
    endfunction

endpackage

// File: design/amx_mixer.sv
// Gain scaling, voice summing and mode normalization, three pipeline stages.
module amx_mixer #(
    parameter int VOICE_COUNT = amx_pkg::NUM_VOICES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [amx_pkg::IN_DATA_W-1:0]       i_data,
    input  logic [amx_pkg::MODE_W-1:0]          i_mix_mode,
    input  logic [amx_pkg::GAINS_W-1:0]         i_voice_gains,
    output logic                                o_valid,
    output logic signed [amx_pkg::SUM_W-1:0]    o_sum
);
    import amx_pkg::*;

    localparam int PROD_W = SAMPLE_W + GAIN_W + 2;
    localparam int NPROD_W = SUM_W + TAB_W + 1;

    logic [GAIN_W:0]             gain_p1 [VOICE_COUNT];
    logic signed [PROD_W-1:0]    prod    [VOICE_COUNT];
    logic [COUNT_W-1:0]          count_raw;
    logic [COUNT_W-1:0]          n_count;
    logic signed [SUM_W-1:0]     n_sum;
    logic signed [NPROD_W-1:0]   norm_prod;
    logic signed [SUM_W-1:0]     n_norm;

    logic                        r_s1_valid;
    logic signed [SAMPLE_W-1:0]  r_scaled [VOICE_COUNT];
    logic [COUNT_W-1:0]          r_s1_count;
    logic [MODE_W-1:0]           r_s1_mode;
    logic                        r_s2_valid;
    logic signed [SUM_W-1:0]     r_s2_sum;
    logic [COUNT_W-1:0]          r_s2_count;
    logic [MODE_W-1:0]           r_s2_mode;
    logic                        r_s3_valid;
    logic signed [SUM_W-1:0]     r_s3_sum;

    // stage 1: sample * (gain + 1) >>> 8
    always_comb begin
        for (int v = 0; v < VOICE_COUNT; v++) begin
            gain_p1[v] = {1'b0, i_voice_gains[v*GAIN_W +: GAIN_W]} + 9'd1;
            prod[v]    = PROD_W'($signed(i_data[v*SAMPLE_W +: SAMPLE_W]))
                       * PROD_W'($signed({1'b0, gain_p1[v]}));
        end
        count_raw = i_data[NUM_VOICES*SAMPLE_W +: COUNT_W];
        n_count   = (count_raw > MAX_PRODUCERS) ? MAX_PRODUCERS : count_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            for (int v = 0; v < VOICE_COUNT; v++) begin
                r_scaled[v] <= prod[v][SAMPLE_W+GAIN_W-1:GAIN_W];
            end
            r_s1_count <= n_count;
            r_s1_mode  <= i_mix_mode;
        end
    end

    // stage 2: sum of the scaled voices
    always_comb begin
        n_sum = '0;
        for (int v = 0; v < VOICE_COUNT; v++) begin
            n_sum = n_sum + SUM_W'(r_scaled[v]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= r_s1_valid;
            r_s2_sum   <= n_sum;
            r_s2_count <= r_s1_count;
            r_s2_mode  <= r_s1_mode;
        end
    end

    // stage 3: normalization
    always_comb begin
        norm_prod = NPROD_W'(r_s2_sum) * NPROD_W'($signed({1'b0, recip_root(r_s2_count)}));
        case (r_s2_mode)
            MODE_PLAIN: n_norm = r_s2_sum;
            MODE_HALVE: n_norm = r_s2_sum >>> 1;
            MODE_SQRT:  n_norm = (r_s2_count > 4'd1) ? norm_prod[SUM_W+7:8] : r_s2_sum;
            default:    n_norm = r_s2_sum;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s3_valid <= r_s2_valid;
            r_s3_sum   <= n_norm;
        end
    end

    assign o_valid = r_s3_valid;
    assign o_sum   = r_s3_sum;

endmodule

// File: design/amx_knee_div.sv
// Soft knee: magnitude, knee offset products and a one-bit-per-stage divider.
module amx_knee_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [amx_pkg::SUM_W-1:0]  i_sum,
    output amx_pkg::t_knee_word               o_word
);
    import amx_pkg::*;

    logic [ABS_W-1:0]  n_abs;

    logic              r_a_valid;
    logic              r_a_neg;
    logic              r_a_knee;
    logic [OFF_W-1:0]  r_a_off;
    logic [MAG_W-1:0]  r_a_mag;

    logic              r_v    [QUO_W+1];
    logic              r_neg  [QUO_W+1];
    logic              r_knee [QUO_W+1];
    logic [MAG_W-1:0]  r_mag  [QUO_W+1];
    logic [DIVD_W-1:0] r_rem  [QUO_W+1];
    logic [OFF_W-1:0]  r_div  [QUO_W+1];
    logic [QUO_W-1:0]  r_q    [QUO_W+1];

    // stage A: magnitude and knee offset
    assign n_abs = i_sum[SUM_W-1] ? ABS_W'(-i_sum) : ABS_W'(i_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_a_neg   <= i_sum[SUM_W-1];
            r_a_knee  <= n_abs > ABS_W'(KNEE_LEVEL);
            r_a_off   <= OFF_W'(n_abs - ABS_W'(KNEE_LEVEL));
            r_a_mag   <= n_abs[MAG_W-1:0];
        end
    end

    // stage B: dividend o*range, divisor o+range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0]    <= r_a_valid;
            r_neg[0]  <= r_a_neg;
            r_knee[0] <= r_a_knee;
            r_mag[0]  <= r_a_mag;
            r_rem[0]  <= DIVD_W'(r_a_off) * DIVD_W'(KNEE_RANGE);
            r_div[0]  <= r_a_off + OFF_W'(KNEE_RANGE);
            r_q[0]    <= '0;
        end
    end

    // restoring divider, quotient MSB first
    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        localparam int BIT = QUO_W - 1 - k;

        logic [DIVD_W:0]   trial;
        logic              ge;
        logic [DIVD_W-1:0] n_rem;
        logic [QUO_W-1:0]  n_q;

        always_comb begin
            trial = (DIVD_W+1)'(r_div[k]) << BIT;
            ge    = {1'b0, r_rem[k]} >= trial;
            n_rem = ge ? DIVD_W'({1'b0, r_rem[k]} - trial) : r_rem[k];
            n_q   = r_q[k] | (QUO_W'(ge) << BIT);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1]    <= r_v[k];
                r_neg[k+1]  <= r_neg[k];
                r_knee[k+1] <= r_knee[k];
                r_mag[k+1]  <= r_mag[k];
                r_rem[k+1]  <= n_rem;
                r_div[k+1]  <= r_div[k];
                r_q[k+1]    <= n_q;
            end
        end
    end

    assign o_word.valid = r_v[QUO_W];
    assign o_word.neg   = r_neg[QUO_W];
    assign o_word.knee  = r_knee[QUO_W];
    assign o_word.mag   = r_mag[QUO_W];
    assign o_word.quo   = r_q[QUO_W];

endmodule

// File: design/amx_out_buf.sv
// Final sign and knee recombination with output register and skid stage.
module amx_out_buf (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  amx_pkg::t_knee_word             i_word,
    input  logic                            i_ready,
    output logic                            o_en,
    output logic                            o_valid,
    output logic [amx_pkg::SAMPLE_W-1:0]    o_data
);
    import amx_pkg::*;
    `include "multi_voice_audio_mix_limiter_defines.svh"

    logic [SAMPLE_W-1:0] mag_full;
    logic [SAMPLE_W-1:0] n_result;
    logic                push;
    logic                pop;

    logic                r_out_v;
    logic [SAMPLE_W-1:0] r_out;
    logic                r_skid_v;
    logic [SAMPLE_W-1:0] r_skid;

    always_comb begin
        mag_full = i_word.knee ? SAMPLE_W'(KNEE_LEVEL) + SAMPLE_W'(i_word.quo)
                               : SAMPLE_W'(i_word.mag);
        n_result = i_word.neg ? -mag_full : mag_full;
    end

    assign o_en = !r_skid_v;
    assign push = o_en && i_word.valid;
    assign pop  = r_out_v && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (pop) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_v || pop) begin
                r_out   <= n_result;
                r_out_v <= 1'b1;
            end else begin
                r_skid   <= n_result;
                r_skid_v <= 1'b1;
            end
        end else if (pop) begin
            r_out_v <= 1'b0;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

    `AMX_ASSERT_IMP(a_skid_has_out, i_clk, i_rst_n, r_skid_v, r_out_v, "skid full with empty output")
    `AMX_ASSERT_NXT(a_blocked_push_skids, i_clk, i_rst_n, !r_skid_v && i_word.valid && r_out_v && !i_ready, r_skid_v, "blocked word not held in skid")
    `AMX_ASSERT_IMP(a_out_range, i_clk, i_rst_n, r_out_v, (r_out != 16'h8000) && (r_out != 16'h8001) && (r_out != 16'h7FFF), "output beyond knee limit")

endmodule

// File: design/multi_voice_audio_mix_limiter.sv
// Top level of the multi-voice audio mixer with soft-knee limiter.
//
//  channel   direction  handshake                         payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready   8 voice samples, producing count
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready   mixed sample
//  cfg       in         i_cfg_valid/o_cfg_ready           register index, write data
//
//  One word per cycle while the output is not stalled. Pipeline: 3 mix stages, 2
//  knee setup stages, 14 divider stages of one quotient bit each, 1 output register.
//  The knee divider sets the depth: one restoring step per stage.
//  Reset clears the valid bits and the configuration registers.
//  When the output stalls a skid register takes one more word; the whole
//  pipeline then holds and o_s_axis_tready drops until the skid drains.
module multi_voice_audio_mix_limiter #(
    parameter int VOICE_COUNT = amx_pkg::NUM_VOICES
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // voice0_sample..voice7_sample [127:0], producing_voices [131:128], zeros [135:132]
    input  logic [amx_pkg::IN_DATA_W-1:0]        i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // mixed_sample [15:0]
    output logic [amx_pkg::SAMPLE_W-1:0]         o_m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [amx_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [amx_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import amx_pkg::*;

    logic                    en;
    logic                    mix_valid;
    logic signed [SUM_W-1:0] mix_sum;
    t_knee_word              knee_word;

    logic [MODE_W-1:0]       r_mix_mode;
    logic [GAINS_W-1:0]      r_voice_gains;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix_mode    <= MODE_PLAIN;
            r_voice_gains <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MIX_MODE:    r_mix_mode    <= i_cfg_data[MODE_W-1:0];
                REG_VOICE_GAINS: r_voice_gains <= i_cfg_data[GAINS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = en;

    amx_mixer #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_mixer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_s_axis_tvalid),
        .i_data        (i_s_axis_tdata),
        .i_mix_mode    (r_mix_mode),
        .i_voice_gains (r_voice_gains),
        .o_valid       (mix_valid),
        .o_sum         (mix_sum)
    );

    amx_knee_div u_knee (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (mix_valid),
        .i_sum   (mix_sum),
        .o_word  (knee_word)
    );

    amx_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (knee_word),
        .i_ready (i_m_axis_tready),
        .o_en    (en),
        .o_valid (o_m_axis_tvalid),
        .o_data  (o_m_axis_tdata)
    );

endmodule

// File: tb/tb_multi_voice_audio_mix_limiter.sv
`timescale 1ns / 1ps
// Self-checking testbench for the multi-voice audio mix limiter: directed, random and stall tests.
module tb_multi_voice_audio_mix_limiter;
    import amx_pkg::*;

    localparam int PIPE_LATENCY = 20;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [MODE_W-1:0]    MODE_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_3 = 2'd3;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN  = 16'h8000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_ZERO = 16'h0000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MID  = 16'd4000;
    localparam logic [GAINS_W-1:0]  GAINS_UNITY = '1;
    localparam logic [GAINS_W-1:0]  GAINS_MUTE  = '0;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_DATA_W-1:0]   i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [SAMPLE_W-1:0]    o_m_axis_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    logic [MODE_W-1:0]      mode_shadow;
    logic [GAINS_W-1:0]     gains_shadow;
    int                     inv_root_q8 [0:8] = '{256, 256, 181, 148, 128, 114, 105, 97, 90};
    logic [MODE_W-1:0]      mode_order [0:3] = '{MODE_PLAIN, MODE_HALVE, MODE_SQRT, MODE_UNUSED};

    logic [SAMPLE_W-1:0]    mixed_expected [$];
    logic [SAMPLE_W-1:0]    mixed_want;
    int                     send_idle_pct;
    int                     recv_idle_pct;
    int                     hold_left;
    int                     words_checked;
    int                     mismatches;
    int                     cycles;

    multi_voice_audio_mix_limiter uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // gain scale, mode normalization, soft knee
    function automatic logic [SAMPLE_W-1:0] mix_and_limit(input logic [IN_DATA_W-1:0] word);
        int                          acc;
        int                          producers;
        int                          mag;
        longint                      over;
        logic signed [SAMPLE_W-1:0]  smp;
        acc = 0;
        for (int v = 0; v < NUM_VOICES; v++) begin
            smp = word[v*SAMPLE_W +: SAMPLE_W];
            acc += (int'(smp) * (int'(gains_shadow[v*GAIN_W +: GAIN_W]) + 1)) >>> 8;
        end
        producers = int'(word[NUM_VOICES*SAMPLE_W +: COUNT_W]);
        if (producers > NUM_VOICES) producers = NUM_VOICES;
        case (mode_shadow)
            MODE_HALVE: acc = acc >>> 1;
            MODE_SQRT: begin
                if (producers > 1) acc = (acc * inv_root_q8[producers]) >>> 8;
            end
            default: ;
        endcase
        mag = (acc < 0) ? -acc : acc;
        if (mag > KNEE_LEVEL) begin
            over = longint'(mag - KNEE_LEVEL);
            over = (over * KNEE_RANGE) / (over + KNEE_RANGE);
            mag  = KNEE_LEVEL + int'(over);
            acc  = (acc < 0) ? -mag : mag;
        end
        return acc[SAMPLE_W-1:0];
    endfunction

    function automatic logic [IN_DATA_W-1:0] voice_word(
        input logic [NUM_VOICES*SAMPLE_W-1:0] lanes,
        input logic [COUNT_W-1:0]             producers
    );
        return {{(IN_DATA_W-IN_FIELDS_W){1'b0}}, producers, lanes};
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        logic [SAMPLE_W-1:0] s;
        case ($urandom_range(5))
            0:       s = SAMPLE_MAX;
            1:       s = SAMPLE_MIN;
            2:       s = SAMPLE_ZERO;
            3:       s = SAMPLE_W'($urandom_range(1023)) - SAMPLE_W'(512);
            default: s = SAMPLE_W'($urandom);
        endcase
        return s;
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_word();
        logic [NUM_VOICES*SAMPLE_W-1:0] lanes;
        logic [COUNT_W-1:0]             producers;
        for (int v = 0; v < NUM_VOICES; v++) lanes[v*SAMPLE_W +: SAMPLE_W] = random_sample();
        if ($urandom_range(3) == 0) producers = COUNT_W'($urandom);
        else producers = COUNT_W'($urandom_range(NUM_VOICES));
        return voice_word(lanes, producers);
    endfunction

    function automatic logic [GAINS_W-1:0] random_gains();
        logic [GAINS_W-1:0] g;
        for (int v = 0; v < NUM_VOICES; v++) begin
            case ($urandom_range(3))
                0:       g[v*GAIN_W +: GAIN_W] = '1;
                1:       g[v*GAIN_W +: GAIN_W] = '0;
                default: g[v*GAIN_W +: GAIN_W] = GAIN_W'($urandom);
            endcase
        end
        return g;
    endfunction

    // each cycle slot idles with the sender idle percentage
    task automatic send_word(input logic [IN_DATA_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (mixed_expected.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == REG_MIX_MODE) mode_shadow = data[MODE_W-1:0];
        else if (idx == REG_VOICE_GAINS) gains_shadow = data;
    endtask

    task automatic test_reset_values();
        send_word(voice_word({NUM_VOICES{SAMPLE_MAX}}, MAX_PRODUCERS));
        send_word(voice_word({NUM_VOICES{SAMPLE_MIN}}, '0));
        drain_results();
    endtask

    task automatic test_directed_modes();
        write_reg(REG_VOICE_GAINS, GAINS_UNITY);
        write_reg(REG_MIX_MODE, MODE_PLAIN);
        send_word(voice_word({NUM_VOICES{SAMPLE_MAX}}, MAX_PRODUCERS));
        send_word(voice_word({NUM_VOICES{SAMPLE_MIN}}, MAX_PRODUCERS));
        send_word(voice_word({NUM_VOICES{SAMPLE_ZERO}}, '0));
        send_word(voice_word({SAMPLE_MAX, {(NUM_VOICES-1){SAMPLE_ZERO}}}, 4'd1));
        send_word(voice_word({(NUM_VOICES/2){SAMPLE_MIN, SAMPLE_MAX}}, '1));
        drain_results();

        write_reg(REG_MIX_MODE, MODE_HALVE);
        send_word(voice_word({NUM_VOICES{SAMPLE_MAX}}, MAX_PRODUCERS));
        send_word(voice_word({NUM_VOICES{SAMPLE_MIN}}, MAX_PRODUCERS));
        drain_results();

        // every table entry, then a count past the clamp
        write_reg(REG_MIX_MODE, MODE_SQRT);
        for (int n = 0; n <= NUM_VOICES; n++)
            send_word(voice_word({NUM_VOICES{SAMPLE_MID}}, COUNT_W'(n)));
        send_word(voice_word({NUM_VOICES{SAMPLE_MIN}}, '1));
        drain_results();

        write_reg(REG_MIX_MODE, MODE_UNUSED);
        send_word(voice_word({NUM_VOICES{SAMPLE_MAX}}, MAX_PRODUCERS));
        drain_results();
    endtask

    task automatic test_unmapped_registers();
        write_reg(REG_MIX_MODE, MODE_HALVE);
        write_reg(REG_UNMAPPED_2, '1);
        write_reg(REG_UNMAPPED_3, '1);
        send_word(voice_word({NUM_VOICES{SAMPLE_MAX}}, MAX_PRODUCERS));
        drain_results();
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct, input int phase);
        logic [GAINS_W-1:0] gains;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int k = 0; k < 4; k++) begin
            case (k)
                0:       gains = GAINS_UNITY;
                1:       gains = GAINS_MUTE;
                default: gains = random_gains();
            endcase
            drain_results();
            write_reg(REG_MIX_MODE, mode_order[(k + phase) % 4]);
            write_reg(REG_VOICE_GAINS, gains);
            repeat (66) send_word(random_word());
        end
        drain_results();
    endtask

    // long receiver hold so the pipeline fills and drops o_s_axis_tready
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_MIX_MODE, MODE_SQRT);
        write_reg(REG_VOICE_GAINS, random_gains());
        hold_left = 200;
        repeat (60) send_word(random_word());
        drain_results();
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            mixed_expected.push_back(mix_and_limit(i_s_axis_tdata));
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (mixed_expected.size() == 0) begin
                $error("mixed_sample: expected none, actual %0d", $signed(o_m_axis_tdata));
                mismatches++;
            end else begin
                mixed_want = mixed_expected.pop_front();
                words_checked++;
                if (o_m_axis_tdata !== mixed_want) begin
                    $error("mixed_sample: expected %0d, actual %0d",
                           $signed(mixed_want), $signed(o_m_axis_tdata));
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("multi_voice_audio_mix_limiter verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_m_axis_tready <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= REG_MIX_MODE;
        i_cfg_data      <= '0;
        mode_shadow   = MODE_PLAIN;
        gains_shadow  = GAINS_MUTE;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 0;
        words_checked = 0;
        mismatches    = 0;
        cycles        = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_directed_modes();
        test_unmapped_registers();
        test_random_phase(18, 79, 0);
        test_random_phase(79, 18, 1);
        test_random_phase(0, 0, 2);
        test_backpressure();

        $display("Checked %0d mixed words across all four mode codes, gain extremes,",
                 words_checked);
        $display("producer counts 0..15, unmapped register writes and a long output stall.");
        if (mismatches == 0 && mixed_expected.size() == 0) begin
            $display("multi_voice_audio_mix_limiter verification clean");
        end else begin
            $display("multi_voice_audio_mix_limiter verification failed");
        end
        $finish;
    end

endmodule

// File: multi_voice_audio_mix_limiter.f
+incdir+design
design/amx_pkg.sv
design/amx_mixer.sv
design/amx_knee_div.sv
design/amx_out_buf.sv
design/multi_voice_audio_mix_limiter.sv
tb/tb_multi_voice_audio_mix_limiter.sv
